[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define CDSA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cdsa assertion failed");

// Check a property on every clock edge, reset included.
`define CDSA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cdsa assertion failed");

`else

`define CDSA_ASSERT(lbl, clk, rst, prop)
`define CDSA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[sv/cdsa_pkg.sv]
package cdsa_pkg;

   localparam int MAX_SPAN_DAYS = 1023;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DOM_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int US_W     = 20;
   localparam int SPAN_D_W = 10;

   // Running day count: day of month plus span plus one carry.
   localparam int DAY_W = $clog2(31 + MAX_SPAN_DAYS + 2);

   localparam int US_PER_SEC = 1000000;
   localparam int YEAR_MAX   = 9999;

   // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for every y up to YEAR_MAX.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int CENT_W      = 7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] M_APR = 4'd4;
   localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] M_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

   // Item after clamping and time-of-day carry, waiting for month rollover.
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [CENT_W-1:0]  cent;   // year / 100
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
      logic [US_W-1:0]    subsec;
   } cdsa_item_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
      logic [US_W-1:0]    subsec;
      logic               overflow;
   } cdsa_result_type;

   function automatic logic [DOM_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DOM_W-1:0] len;
      case (month)
         M_FEB:   len = leap ? 5'd29 : 5'd28;
         M_APR:   len = 5'd30;
         M_JUN:   len = 5'd30;
         M_SEP:   len = 5'd30;
         M_NOV:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[sv/cdsa_front.sv]
module cdsa_front import cdsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [YEAR_W-1:0]   year_in,
   input  logic [MONTH_W-1:0]  month_in,
   input  logic [DOM_W-1:0]    day_in,
   input  logic [HOUR_W-1:0]   hour_in,
   input  logic [MIN_W-1:0]    minute_in,
   input  logic [SEC_W-1:0]    second_in,
   input  logic [US_W-1:0]     subsec_in,
   input  logic [SPAN_D_W-1:0] span_days,
   input  logic [HOUR_W-1:0]   span_hours,
   input  logic [MIN_W-1:0]    span_minutes,
   input  logic [SEC_W-1:0]    span_seconds,
   input  logic [US_W-1:0]     span_subsec,
   output logic                item_valid,
   input  logic                item_take,
   output cdsa_item_type       item
);

   logic [YEAR_W-1:0]  year_c;
   logic [MONTH_W-1:0] month_c;
   logic [DOM_W-1:0]   day_c;
   logic [HOUR_W-1:0]  hr_c, sh_c;
   logic [MIN_W-1:0]   mi_c, sm_c;
   logic [SEC_W-1:0]   se_c, ss_c;
   logic [US_W-1:0]    us_c, su_c;
   logic [DAY_W-1:0]   sd_c;
   logic [US_W:0]      us_sum;
   logic [SEC_W:0]     se_sum;
   logic [MIN_W:0]     mi_sum;
   logic [HOUR_W:0]    hr_sum;
   logic               c_us, c_se, c_mi, c_hr;
   logic [YEAR_W+13:0] year_scaled;
   cdsa_item_type      new_item;

   cdsa_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      year_c  = (year_in > YEAR_W'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX) : year_in;
      month_c = (month_in < M_JAN) ? M_JAN : ((month_in > M_DEC) ? M_DEC : month_in);
      day_c   = (day_in == '0) ? DOM_W'(1) : day_in;
      hr_c    = (hour_in > HOUR_W'(23)) ? HOUR_W'(23) : hour_in;
      mi_c    = (minute_in > MIN_W'(59)) ? MIN_W'(59) : minute_in;
      se_c    = (second_in > SEC_W'(59)) ? SEC_W'(59) : second_in;
      us_c    = (subsec_in > US_W'(US_PER_SEC - 1)) ? US_W'(US_PER_SEC - 1) : subsec_in;
      sh_c    = (span_hours > HOUR_W'(23)) ? HOUR_W'(23) : span_hours;
      sm_c    = (span_minutes > MIN_W'(59)) ? MIN_W'(59) : span_minutes;
      ss_c    = (span_seconds > SEC_W'(59)) ? SEC_W'(59) : span_seconds;
      su_c    = (span_subsec > US_W'(US_PER_SEC - 1)) ? US_W'(US_PER_SEC - 1) : span_subsec;
      sd_c    = (32'(span_days) > 32'(MAX_SPAN_DAYS)) ? DAY_W'(MAX_SPAN_DAYS)
                                                      : DAY_W'(span_days);

      // Time-of-day add, one carry per unit.
      us_sum = {1'b0, us_c} + {1'b0, su_c};
      c_us   = us_sum >= (US_W+1)'(US_PER_SEC);
      se_sum = {1'b0, se_c} + {1'b0, ss_c} + (SEC_W+1)'(c_us);
      c_se   = se_sum >= (SEC_W+1)'(60);
      mi_sum = {1'b0, mi_c} + {1'b0, sm_c} + (MIN_W+1)'(c_se);
      c_mi   = mi_sum >= (MIN_W+1)'(60);
      hr_sum = {1'b0, hr_c} + {1'b0, sh_c} + (HOUR_W+1)'(c_mi);
      c_hr   = hr_sum >= (HOUR_W+1)'(24);

      year_scaled = (YEAR_W+14)'(year_c) * (YEAR_W+14)'(RECIP_100);

      new_item.year   = year_c;
      new_item.cent   = CENT_W'(year_scaled >> RECIP_SHIFT);
      new_item.month  = month_c;
      new_item.day    = DAY_W'(day_c) + sd_c + DAY_W'(c_hr);
      new_item.hour   = c_hr ? HOUR_W'(hr_sum - (HOUR_W+1)'(24)) : HOUR_W'(hr_sum);
      new_item.minute = c_mi ? MIN_W'(mi_sum - (MIN_W+1)'(60)) : MIN_W'(mi_sum);
      new_item.second = c_se ? SEC_W'(se_sum - (SEC_W+1)'(60)) : SEC_W'(se_sum);
      new_item.subsec = c_us ? US_W'(us_sum - (US_W+1)'(US_PER_SEC)) : US_W'(us_sum);
   end

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign item_valid = count_ff != '0;
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[sv/cdsa_back.sv]
module cdsa_back import cdsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   output logic            item_take,
   input  cdsa_item_type   item,
   output logic            out_valid,
   input  logic            out_take,
   output cdsa_result_type result
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_ROLL = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [HOUR_W-1:0]  hour_ff;
   logic [MIN_W-1:0]   minute_ff;
   logic [SEC_W-1:0]   second_ff;
   logic [US_W-1:0]    subsec_ff;
   logic [CENT_W-1:0]  r100_ff, r100_in;   // year mod 100
   logic [1:0]         c4_ff, c4_in;       // (year / 100) mod 4
   logic               ovf_ff, ovf_in;
   logic               out_valid_ff, out_valid_in;
   cdsa_result_type    result_ff, result_in;

   logic               leap;
   logic [DOM_W-1:0]   dim;
   logic               past_end, wrap, sat, done, ovf_now, out_free;
   logic [YEAR_W-1:0]  cent_x100;

   always_comb begin
      cent_x100 = (YEAR_W'(item.cent) << 6) + (YEAR_W'(item.cent) << 5)
                + (YEAR_W'(item.cent) << 2);
      leap      = (r100_ff == '0) ? (c4_ff == 2'd0) : (year_ff[1:0] == 2'd0);
      dim       = month_days(month_ff, leap);
      past_end  = day_ff > DAY_W'(dim);
      wrap      = month_ff == M_DEC;
      sat       = past_end && wrap && (year_ff >= YEAR_W'(YEAR_MAX));
      ovf_now   = ovf_ff || sat;
      done      = ovf_now || !past_end;
      out_free  = !out_valid_ff || out_take;
   end

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      r100_in      = r100_ff;
      c4_in        = c4_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && !out_take;
      result_in    = result_ff;
      item_take    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               year_in   = item.year;
               month_in  = item.month;
               day_in    = item.day;
               r100_in   = CENT_W'(item.year - cent_x100);
               c4_in     = item.cent[1:0];
               ovf_in    = 1'b0;
               state_in  = S_ROLL;
            end
         end
         S_ROLL: begin
            if (done) begin
               // Hold here until the result register frees up.
               ovf_in = ovf_now;
               if (out_free) begin
                  out_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (ovf_now) begin
                     result_in.year   = YEAR_W'(YEAR_MAX);
                     result_in.month  = M_DEC;
                     result_in.day    = DOM_W'(31);
                     result_in.hour   = HOUR_W'(23);
                     result_in.minute = MIN_W'(59);
                     result_in.second = SEC_W'(59);
                     result_in.subsec = US_W'(US_PER_SEC - 1);
                  end else begin
                     result_in.year   = year_ff;
                     result_in.month  = month_ff;
                     result_in.day    = DOM_W'(day_ff);
                     result_in.hour   = hour_ff;
                     result_in.minute = minute_ff;
                     result_in.second = second_ff;
                     result_in.subsec = subsec_ff;
                  end
                  result_in.overflow = ovf_now;
               end
            end else begin
               // Advance one month.
               day_in = day_ff - DAY_W'(dim);
               if (wrap) begin
                  month_in = M_JAN;
                  year_in  = year_ff + 1'b1;
                  if (r100_ff == CENT_W'(99)) begin
                     r100_in = '0;
                     c4_in   = c4_ff + 1'b1;
                  end else begin
                     r100_in = r100_ff + 1'b1;
                  end
               end else begin
                  month_in = month_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      r100_ff   <= r100_in;
      c4_ff     <= c4_in;
      ovf_ff    <= ovf_in;
      result_ff <= result_in;
      if (item_take) begin
         hour_ff   <= item.hour;
         minute_ff <= item.minute;
         second_ff <= item.second;
         subsec_ff <= item.subsec;
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule

[sv/calendar_date_span_adder_unit.sv]
// Each item passes through the two-entry front queue, then the back end rolls its surplus days
// forward one month per cycle; the back end takes a new item only once the last is in the result register.
// A two-entry item queue takes new items while the rollover sequencer is busy,
// and the result register frees the sequencer while a result waits for pop.
// Reset (synchronous, active high) empties the queue and result register and idles
// the sequencer.
`include "assert_macros.svh"

module calendar_date_span_adder_unit import cdsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [YEAR_W-1:0]   req_year_in,
   input  logic [MONTH_W-1:0]  req_month_in,
   input  logic [DOM_W-1:0]    req_day_in,
   input  logic [HOUR_W-1:0]   req_hour_in,
   input  logic [MIN_W-1:0]    req_minute_in,
   input  logic [SEC_W-1:0]    req_second_in,
   input  logic [US_W-1:0]     req_subsec_in,
   input  logic [SPAN_D_W-1:0] req_span_days,
   input  logic [HOUR_W-1:0]   req_span_hours,
   input  logic [MIN_W-1:0]    req_span_minutes,
   input  logic [SEC_W-1:0]    req_span_seconds,
   input  logic [US_W-1:0]     req_span_subsec,
   output logic                empty,
   input  logic                pop,
   output logic [YEAR_W-1:0]   rsp_year_out,
   output logic [MONTH_W-1:0]  rsp_month_out,
   output logic [DOM_W-1:0]    rsp_day_out,
   output logic [HOUR_W-1:0]   rsp_hour_out,
   output logic [MIN_W-1:0]    rsp_minute_out,
   output logic [SEC_W-1:0]    rsp_second_out,
   output logic [US_W-1:0]     rsp_subsec_out,
   output logic                rsp_year_overflow
);

   // Front: clamp the fields, add the time of day with its carries, and
   // split the year into centuries; queue the item for the back end.
   logic            item_valid, item_take;
   cdsa_item_type   item;
   logic            out_valid;
   cdsa_result_type result;

   cdsa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .year_in      (req_year_in),
      .month_in     (req_month_in),
      .day_in       (req_day_in),
      .hour_in      (req_hour_in),
      .minute_in    (req_minute_in),
      .second_in    (req_second_in),
      .subsec_in    (req_subsec_in),
      .span_days    (req_span_days),
      .span_hours   (req_span_hours),
      .span_minutes (req_span_minutes),
      .span_seconds (req_span_seconds),
      .span_subsec  (req_span_subsec),
      .item_valid   (item_valid),
      .item_take    (item_take),
      .item         (item)
   );

   // Back: roll surplus days forward one month per cycle, with the leap-year
   // rule tracked incrementally, and saturate past December 9999.
   cdsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .out_valid  (out_valid),
      .out_take   (pop),
      .result     (result)
   );

   assign empty             = !out_valid;
   assign rsp_year_out      = result.year;
   assign rsp_month_out     = result.month;
   assign rsp_day_out       = result.day;
   assign rsp_hour_out      = result.hour;
   assign rsp_minute_out    = result.minute;
   assign rsp_second_out    = result.second;
   assign rsp_subsec_out    = result.subsec;
   assign rsp_year_overflow = result.overflow;

   // A waiting result always carries a real month and a one-based day.
   `CDSA_ASSERT(a_month_range, clock, reset, !empty |-> (rsp_month_out >= M_JAN && rsp_month_out <= M_DEC && rsp_day_out != '0))
   // Overflow always comes with the saturated end-of-range date.
   `CDSA_ASSERT(a_ovf_sat, clock, reset, (!empty && rsp_year_overflow) |-> (rsp_year_out == YEAR_W'(YEAR_MAX) && rsp_day_out == DOM_W'(31)))
   // Reset leaves the result register empty and the item queue not full.
   `CDSA_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (empty && !full))
   // The back end never takes an item from an empty queue.
   `CDSA_ASSERT(a_take_valid, clock, reset, item_take |-> item_valid)

endmodule

[test/calendar_date_span_adder_unit_test.sv]
module calendar_date_span_adder_unit_test;
   import cdsa_pkg::*;

   // One start date plus the span to add, laid out like the request ports.
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DOM_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MIN_W-1:0]    minute;
      logic [SEC_W-1:0]    second;
      logic [US_W-1:0]     subsec;
      logic [SPAN_D_W-1:0] sp_days;
      logic [HOUR_W-1:0]   sp_hours;
      logic [MIN_W-1:0]    sp_minutes;
      logic [SEC_W-1:0]    sp_seconds;
      logic [US_W-1:0]     sp_subsec;
   } date_span_type;

   // Receiver stall patterns; each runs for a random stretch of cycles.
   typedef enum int unsigned {
      POP_STEADY,
      POP_COIN,
      POP_SPARSE,
      POP_BLOCKS
   } pop_mode_type;

   // Predicts the sum for every accepted item and checks results in order.
   class date_sum_board;
      cdsa_result_type pending_sums[$];
      int unsigned     sums_checked;
      int unsigned     saturations;
      int unsigned     faults;

      function int unsigned clip(int unsigned v, int unsigned hi);
         return (v > hi) ? hi : v;
      endfunction

      function bit leap(int unsigned y);
         return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
      endfunction

      function int unsigned days_of(int unsigned y, int unsigned m);
         int unsigned len;
         case (m)
            M_FEB:                      len = leap(y) ? 29 : 28;
            M_APR, M_JUN, M_SEP, M_NOV: len = 30;
            default:                    len = 31;
         endcase
         return len;
      endfunction

      function cdsa_result_type add_span(date_span_type s);
         int unsigned year, mon, day, hr, mi, se, us, carry, dim;
         bit ovf;
         cdsa_result_type r;
         year = clip(s.year, YEAR_MAX);
         mon  = s.month;
         day  = s.day;
         hr   = clip(s.hour, 23);
         mi   = clip(s.minute, 59);
         se   = clip(s.second, 59);
         us   = clip(s.subsec, US_PER_SEC - 1);
         if (mon < 1) mon = 1;
         if (mon > 12) mon = 12;
         if (day < 1) day = 1;

         us = us + clip(s.sp_subsec, US_PER_SEC - 1);
         carry = 0;
         if (us >= US_PER_SEC) begin
            us = us - US_PER_SEC;
            carry = 1;
         end
         se = se + clip(s.sp_seconds, 59) + carry;
         carry = 0;
         if (se >= 60) begin
            se = se - 60;
            carry = 1;
         end
         mi = mi + clip(s.sp_minutes, 59) + carry;
         carry = 0;
         if (mi >= 60) begin
            mi = mi - 60;
            carry = 1;
         end
         hr = hr + clip(s.sp_hours, 23) + carry;
         carry = 0;
         if (hr >= 24) begin
            hr = hr - 24;
            carry = 1;
         end
         day = day + clip(s.sp_days, MAX_SPAN_DAYS) + carry;

         // Roll whole months off the day count, stop once December 9999 is passed.
         ovf = 1'b0;
         dim = days_of(year, mon);
         while (day > dim && !ovf) begin
            day = day - dim;
            mon = mon + 1;
            if (mon > 12) begin
               mon = 1;
               if (year >= YEAR_MAX) ovf = 1'b1;
               else year = year + 1;
            end
            dim = days_of(year, mon);
         end

         if (ovf) begin
            year = YEAR_MAX;
            mon  = 12;
            day  = 31;
            hr   = 23;
            mi   = 59;
            se   = 59;
            us   = US_PER_SEC - 1;
         end

         r.year     = YEAR_W'(year);
         r.month    = MONTH_W'(mon);
         r.day      = DOM_W'(day);
         r.hour     = HOUR_W'(hr);
         r.minute   = MIN_W'(mi);
         r.second   = SEC_W'(se);
         r.subsec   = US_W'(us);
         r.overflow = ovf;
         return r;
      endfunction

      function void note_start(date_span_type s);
         pending_sums.push_back(add_span(s));
      endfunction

      // Print one line per mismatch, and stop printing after 40.
      task report(string msg);
         faults++;
         if (faults <= 40) $display("mismatch at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, int unsigned got, int unsigned want, int unsigned idx);
         if (got != want)
            report($sformatf("sum %0d %s is %0d, want %0d", idx, name, got, want));
      endtask

      task check_sum(cdsa_result_type got);
         cdsa_result_type want;
         if (pending_sums.size() == 0) begin
            report("result popped with no item waiting");
         end else begin
            want = pending_sums.pop_front();
            compare_field("year", got.year, want.year, sums_checked);
            compare_field("month", got.month, want.month, sums_checked);
            compare_field("day", got.day, want.day, sums_checked);
            compare_field("hour", got.hour, want.hour, sums_checked);
            compare_field("minute", got.minute, want.minute, sums_checked);
            compare_field("second", got.second, want.second, sums_checked);
            compare_field("subsec", got.subsec, want.subsec, sums_checked);
            compare_field("year_overflow", got.overflow, want.overflow, sums_checked);
            if (want.overflow) saturations++;
            sums_checked++;
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                push;
   logic                full;
   logic                empty;
   logic                pop;
   logic [YEAR_W-1:0]   req_year_in;
   logic [MONTH_W-1:0]  req_month_in;
   logic [DOM_W-1:0]    req_day_in;
   logic [HOUR_W-1:0]   req_hour_in;
   logic [MIN_W-1:0]    req_minute_in;
   logic [SEC_W-1:0]    req_second_in;
   logic [US_W-1:0]     req_subsec_in;
   logic [SPAN_D_W-1:0] req_span_days;
   logic [HOUR_W-1:0]   req_span_hours;
   logic [MIN_W-1:0]    req_span_minutes;
   logic [SEC_W-1:0]    req_span_seconds;
   logic [US_W-1:0]     req_span_subsec;
   logic [YEAR_W-1:0]   rsp_year_out;
   logic [MONTH_W-1:0]  rsp_month_out;
   logic [DOM_W-1:0]    rsp_day_out;
   logic [HOUR_W-1:0]   rsp_hour_out;
   logic [MIN_W-1:0]    rsp_minute_out;
   logic [SEC_W-1:0]    rsp_second_out;
   logic [US_W-1:0]     rsp_subsec_out;
   logic                rsp_year_overflow;

   date_sum_board   sums = new();
   date_span_type   seen_start;
   cdsa_result_type seen_sum;
   pop_mode_type    pop_mode = POP_STEADY;
   int unsigned     pop_left = 0;
   int unsigned     directed_count = 0;
   int unsigned     random_count = 0;

   calendar_date_span_adder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_year_in       (req_year_in),
      .req_month_in      (req_month_in),
      .req_day_in        (req_day_in),
      .req_hour_in       (req_hour_in),
      .req_minute_in     (req_minute_in),
      .req_second_in     (req_second_in),
      .req_subsec_in     (req_subsec_in),
      .req_span_days     (req_span_days),
      .req_span_hours    (req_span_hours),
      .req_span_minutes  (req_span_minutes),
      .req_span_seconds  (req_span_seconds),
      .req_span_subsec   (req_span_subsec),
      .empty             (empty),
      .pop               (pop),
      .rsp_year_out      (rsp_year_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_day_out       (rsp_day_out),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out),
      .rsp_subsec_out    (rsp_subsec_out),
      .rsp_year_overflow (rsp_year_overflow)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Sample both handshakes at the rising edge; inputs only move on the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            seen_start = '{req_year_in, req_month_in, req_day_in, req_hour_in,
                           req_minute_in, req_second_in, req_subsec_in, req_span_days,
                           req_span_hours, req_span_minutes, req_span_seconds,
                           req_span_subsec};
            sums.note_start(seen_start);
         end
         if (pop && !empty) begin
            seen_sum = '{rsp_year_out, rsp_month_out, rsp_day_out, rsp_hour_out,
                         rsp_minute_out, rsp_second_out, rsp_subsec_out,
                         rsp_year_overflow};
            sums.check_sum(seen_sum);
         end
      end
   end

   // Receiver: switch to a random stall pattern once the current one runs out.
   always @(negedge clock) begin
      if (pop_left == 0) begin
         pop_mode = pop_mode_type'($urandom_range(POP_STEADY, POP_BLOCKS));
         pop_left = $urandom_range(16, 160);
      end else begin
         pop_left--;
      end
      case (pop_mode)
         POP_STEADY: pop <= 1'b1;
         POP_COIN:   pop <= 1'($urandom_range(0, 1));
         POP_SPARSE: pop <= ($urandom_range(0, 5) == 0);
         default:    pop <= ((pop_left % 40) < 12);   // long blocks of stall
      endcase
   end

   // Present one item at the falling edge and hold it until it is taken.
   task automatic send_item(date_span_type s);
      @(negedge clock);
      req_year_in      = s.year;
      req_month_in     = s.month;
      req_day_in       = s.day;
      req_hour_in      = s.hour;
      req_minute_in    = s.minute;
      req_second_in    = s.second;
      req_subsec_in    = s.subsec;
      req_span_days    = s.sp_days;
      req_span_hours   = s.sp_hours;
      req_span_minutes = s.sp_minutes;
      req_span_seconds = s.sp_seconds;
      req_span_subsec  = s.sp_subsec;
      push             = 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Drop push for a gap and scramble the idle bus so ignored values move too.
   task automatic hold_off(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         push          = 1'b0;
         req_year_in   = YEAR_W'($urandom);
         req_span_days = SPAN_D_W'($urandom);
      end
   endtask

   function automatic date_span_type span_of(int unsigned y, int unsigned mo, int unsigned d,
                                             int unsigned h, int unsigned mi, int unsigned s,
                                             int unsigned us, int unsigned sd,
                                             int unsigned sh, int unsigned sm,
                                             int unsigned ss, int unsigned su);
      date_span_type r;
      r = '{YEAR_W'(y), MONTH_W'(mo), DOM_W'(d), HOUR_W'(h), MIN_W'(mi), SEC_W'(s),
            US_W'(us), SPAN_D_W'(sd), HOUR_W'(sh), MIN_W'(sm), SEC_W'(ss), US_W'(su)};
      return r;
   endfunction

   // Mostly well-formed dates with random content; some raw noise in every bit.
   function automatic date_span_type random_item();
      date_span_type r;
      logic [127:0]  noise;
      int unsigned   pick;
      int unsigned   y;
      int unsigned   m;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         noise = {$urandom, $urandom, $urandom, $urandom};
         r = noise[$bits(date_span_type)-1:0];
      end else begin
         if ($urandom_range(0, 7) == 0) y = $urandom_range(9995, YEAR_MAX);
         else y = $urandom_range(1970, YEAR_MAX);
         m = $urandom_range(1, 12);
         r = span_of(y, m, $urandom_range(1, sums.days_of(y, m)), $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 59),
                     $urandom_range(0, US_PER_SEC - 1),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, MAX_SPAN_DAYS),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                     $urandom_range(0, US_PER_SEC - 1));
         // Break the time-of-day fields, or the month and day, now and then to reach the clamps.
         if (pick == 2) begin
            r.hour   = HOUR_W'($urandom);
            r.minute = MIN_W'($urandom);
            r.second = SEC_W'($urandom);
            r.subsec = US_W'($urandom);
         end
         if (pick == 3) begin
            r.month = MONTH_W'($urandom);
            r.day   = DOM_W'($urandom);
         end
      end
      return r;
   endfunction

   task automatic send_directed(date_span_type s);
      send_item(s);
      directed_count++;
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 3));
   endtask

   initial begin
      int unsigned burst;
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_year_in      = '0;
      req_month_in     = '0;
      req_day_in       = '0;
      req_hour_in      = '0;
      req_minute_in    = '0;
      req_second_in    = '0;
      req_subsec_in    = '0;
      req_span_days    = '0;
      req_span_hours   = '0;
      req_span_minutes = '0;
      req_span_seconds = '0;
      req_span_subsec  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, carries, leap rules, clamps and the year ceiling.
      send_directed(span_of(1970, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_directed(span_of(16383, 15, 31, 31, 63, 63, 20'hFFFFF, 1023, 31, 63, 63,
                            20'hFFFFF));
      send_directed(span_of(1999, 12, 31, 23, 59, 59, 999999, 0, 0, 0, 0, 1));
      send_directed(span_of(2000, 2, 28, 12, 0, 0, 0, 1, 0, 0, 0, 0));
      send_directed(span_of(1900, 2, 28, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      send_directed(span_of(2024, 2, 29, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      send_directed(span_of(2023, 2, 28, 23, 0, 0, 0, 0, 1, 0, 0, 0));
      send_directed(span_of(2023, 1, 31, 0, 0, 0, 0, 0, 23, 59, 59, 999999));
      // month zero and day zero, months past December
      send_directed(span_of(2023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_directed(span_of(2023, 13, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_directed(span_of(2023, 15, 31, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      // day beyond its month rolls forward
      send_directed(span_of(2023, 2, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_directed(span_of(2023, 4, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // years below the range are used as given, year zero is a leap year
      send_directed(span_of(0, 2, 28, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      send_directed(span_of(1969, 12, 31, 23, 59, 59, 999999, 0, 0, 0, 0, 1));
      // years above the range clamp without the flag
      send_directed(span_of(12000, 6, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // the year ceiling: saturate just past it, not just below it
      send_directed(span_of(9999, 12, 31, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      send_directed(span_of(9999, 12, 31, 23, 59, 59, 999999, 0, 0, 0, 0, 1));
      send_directed(span_of(9999, 12, 31, 23, 59, 59, 999998, 0, 0, 0, 0, 1));
      send_directed(span_of(9997, 3, 1, 0, 0, 0, 0, 1023, 23, 59, 59, 999999));
      // time fields and span fields past their ranges clamp
      send_directed(span_of(2020, 5, 10, 31, 63, 63, 20'hFFFFF, 0, 0, 0, 0, 0));
      send_directed(span_of(2020, 5, 10, 0, 0, 0, 0, 1023, 31, 63, 63, 20'hFFFFF));
      // longest month walk
      send_directed(span_of(1970, 1, 1, 0, 0, 0, 0, 1023, 23, 59, 59, 999999));

      // Random: bursts back to back, with gaps of random length between some.
      while (random_count < 1000) begin
         burst = $urandom_range(1, 16);
         repeat (burst) send_item(random_item());
         random_count += burst;
         if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 24));
      end
      @(negedge clock);
      push = 1'b0;

      // Drain, then give the block time to show any stray result.
      while (sums.pending_sums.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d date sums (%0d directed, %0d random), %0d saturated at the year ceiling,",
               sums.sums_checked, directed_count, random_count, sums.saturations);
      $display("with bursty pushes and changing pop stall patterns; %0d mismatches", sums.faults);
      if (sums.faults == 0) begin
         $display("** calendar_date_span_adder_unit: PASSED **");
      end else begin
         $display("** calendar_date_span_adder_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("timeout with %0d sums still expected", sums.pending_sums.size());
      $display("** calendar_date_span_adder_unit: FAILED **");
      $finish;
   end

endmodule
